>>> rtl/core/btid_pkg.sv
// btid_pkg: shared constants for the ber tlv integer decoder
// status codes and default limits; no dependencies
`timescale 1ns / 1ps

package btid_pkg;

	localparam int DEF_MAX_TAG_OCTETS    = 8;
	localparam int DEF_MAX_LENGTH_OCTETS = 8;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_TAGLONG = 3'd1;
	localparam logic [2:0] ST_INDEF   = 3'd2;
	localparam logic [2:0] ST_LENOCT  = 3'd3;
	localparam logic [2:0] ST_BADINT  = 3'd4;
	localparam logic [2:0] ST_TRUNC   = 3'd5;

	localparam logic [4:0] HIGH_TAG_MARK = 5'h1f;
	localparam int         MAX_INT_OCTETS = 8;

endpackage

>>> rtl/core/ber_tlv_integer_decoder.sv
// ber_tlv_integer_decoder: one octet per item, parses identifier, length, integer value
// depends on btid_pkg; checked by btid_checker
// an accepted octet passes through the input register and then the result register
// throughput: one item per cycle while out_stall is low; each octet is a single state update
// a result is emitted only on completion, error or data_ended
// reset: arst_n asynchronous active low, clears phase, accumulators and both valid flags
`timescale 1ns / 1ps

module ber_tlv_integer_decoder
	import btid_pkg::*;
#(
	parameter int MAX_TAG_OCTETS    = DEF_MAX_TAG_OCTETS,
	parameter int MAX_LENGTH_OCTETS = DEF_MAX_LENGTH_OCTETS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        data_ended,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  tag_class,
	output logic        constructed,
	output logic [55:0] tag_number,
	output logic [63:0] content_length,
	output logic [63:0] int_value,
	output logic [2:0]  status
);

	localparam int TagCntW = $clog2(MAX_TAG_OCTETS + 1);
	localparam int LenCntW = $clog2(MAX_LENGTH_OCTETS + 1);

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_TAG  = 3'd1,
		PH_LEN  = 3'd2,
		PH_LENX = 3'd3,
		PH_VAL  = 3'd4
	} phase_t;

	// input register
	logic       in_valid_s1;
	logic [7:0] byte_s1;
	logic       ended_s1;

	// element state
	phase_t              phase_q, phase_n;
	logic [1:0]          cls_q, cls_n;
	logic                cons_q, cons_n;
	logic [55:0]         tag_q, tag_n;
	logic [TagCntW-1:0]  tcnt_q, tcnt_n;
	logic [63:0]         len_q, len_n;
	logic [LenCntW-1:0]  lleft_q, lleft_n;
	logic [63:0]         val_q, val_n;
	logic [3:0]          vleft_q, vleft_n;

	logic       emit;
	logic [2:0] st;
	logic       do_begin;
	logic       advance;

	// result register
	logic        res_valid_q;
	logic [1:0]  cls_res_q;
	logic        cons_res_q;
	logic [55:0] tag_res_q;
	logic [63:0] len_res_q;
	logic [63:0] int_res_q;
	logic [2:0]  st_res_q;

	assign advance  = !res_valid_q || !out_stall;
	assign in_stall = in_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			byte_s1     <= '0;
			ended_s1    <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
			byte_s1     <= in_byte;
			ended_s1    <= data_ended;
		end
	end

	always_comb begin
		phase_n  = phase_q;
		cls_n    = cls_q;
		cons_n   = cons_q;
		tag_n    = tag_q;
		tcnt_n   = tcnt_q;
		len_n    = len_q;
		lleft_n  = lleft_q;
		val_n    = val_q;
		vleft_n  = vleft_q;
		emit     = 1'b0;
		st       = ST_OK;
		do_begin = 1'b0;
		if (in_valid_s1) begin
			if (ended_s1) begin
				if (phase_q == PH_IDLE) begin
					cls_n   = '0;
					cons_n  = 1'b0;
					tag_n   = '0;
					tcnt_n  = '0;
					len_n   = '0;
					lleft_n = '0;
					val_n   = '0;
					vleft_n = '0;
				end
				emit = 1'b1;
				st   = ST_TRUNC;
			end else begin
				unique case (phase_q)
					PH_TAG: begin
						tag_n  = {tag_q[48:0], byte_s1[6:0]};
						tcnt_n = tcnt_q + TagCntW'(1);
						if (byte_s1[7]) begin
							if (tcnt_n >= TagCntW'(MAX_TAG_OCTETS)) begin
								emit = 1'b1;
								st   = ST_TAGLONG;
							end
						end else if (tag_n < 56'd31) begin
							emit = 1'b1;
							st   = ST_TAGLONG;
						end else begin
							phase_n = PH_LEN;
						end
					end
					PH_LEN: begin
						if (!byte_s1[7]) begin
							len_n    = {57'd0, byte_s1[6:0]};
							do_begin = 1'b1;
						end else if (byte_s1[6:0] == 7'd0) begin
							emit = 1'b1;
							st   = ST_INDEF;
						end else if (byte_s1[6:0] > 7'(MAX_LENGTH_OCTETS)) begin
							emit = 1'b1;
							st   = ST_LENOCT;
						end else begin
							len_n   = '0;
							lleft_n = byte_s1[LenCntW-1:0];
							phase_n = PH_LENX;
						end
					end
					PH_LENX: begin
						len_n = {len_q[55:0], byte_s1};
						if (lleft_q != '0) begin
							lleft_n = lleft_q - LenCntW'(1);
						end
						if (lleft_n == '0) begin
							do_begin = 1'b1;
						end
					end
					PH_VAL: begin
						val_n = {val_q[55:0], byte_s1};
						if (vleft_q != 4'd0) begin
							vleft_n = vleft_q - 4'd1;
						end
						if (vleft_n == 4'd0) begin
							emit = 1'b1;
							st   = ST_OK;
						end
					end
					default: begin
						cls_n   = byte_s1[7:6];
						cons_n  = byte_s1[5];
						tcnt_n  = '0;
						len_n   = '0;
						lleft_n = '0;
						val_n   = '0;
						vleft_n = '0;
						if (byte_s1[4:0] == HIGH_TAG_MARK) begin
							tag_n   = '0;
							phase_n = PH_TAG;
						end else begin
							tag_n   = {51'd0, byte_s1[4:0]};
							phase_n = PH_LEN;
						end
					end
				endcase
				if (do_begin) begin
					if (len_n == 64'd0 || len_n > 64'(MAX_INT_OCTETS)) begin
						emit = 1'b1;
						st   = ST_BADINT;
					end else begin
						val_n   = '0;
						vleft_n = len_n[3:0];
						phase_n = PH_VAL;
					end
				end
			end
			if (emit) begin
				phase_n = PH_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cls_q       <= '0;
			cons_q      <= 1'b0;
			tag_q       <= '0;
			tcnt_q      <= '0;
			len_q       <= '0;
			lleft_q     <= '0;
			val_q       <= '0;
			vleft_q     <= '0;
			res_valid_q <= 1'b0;
			cls_res_q   <= '0;
			cons_res_q  <= 1'b0;
			tag_res_q   <= '0;
			len_res_q   <= '0;
			int_res_q   <= '0;
			st_res_q    <= ST_OK;
		end else if (advance) begin
			if (in_valid_s1) begin
				phase_q <= phase_n;
				cls_q   <= cls_n;
				cons_q  <= cons_n;
				tag_q   <= tag_n;
				tcnt_q  <= tcnt_n;
				len_q   <= len_n;
				lleft_q <= lleft_n;
				val_q   <= val_n;
				vleft_q <= vleft_n;
			end
			res_valid_q <= in_valid_s1 && emit;
			if (in_valid_s1 && emit) begin
				cls_res_q  <= cls_n;
				cons_res_q <= cons_n;
				tag_res_q  <= tag_n;
				len_res_q  <= len_n;
				int_res_q  <= (st == ST_OK) ? val_n : 64'd0;
				st_res_q   <= st;
			end
		end
	end

	assign out_valid      = res_valid_q;
	assign tag_class      = cls_res_q;
	assign constructed    = cons_res_q;
	assign tag_number     = tag_res_q;
	assign content_length = len_res_q;
	assign int_value      = int_res_q;
	assign status         = st_res_q;

endmodule

>>> rtl/core/btid_checker.sv
// btid_checker: port-level assertions for ber_tlv_integer_decoder
// depends on btid_pkg; bound to ber_tlv_integer_decoder below
`timescale 1ns / 1ps

module btid_checker
	import btid_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] content_length,
	input logic [63:0] int_value,
	input logic [2:0]  status
);

	// stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(int_value) && $stable(status))
		else $error("stalled result item changed");

	// value only on success
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> int_value == 64'd0)
		else $error("nonzero value on error");

	// ok needs a legal integer length
	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> content_length >= 64'd1 && content_length <= 64'd8)
		else $error("ok with bad length");

	// bad integer length really is bad
	a_bad_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_BADINT |-> content_length == 64'd0 || content_length > 64'd8)
		else $error("bad length status with legal length");

	// indefinite form leaves length untouched
	a_indef: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_INDEF |-> content_length == 64'd0)
		else $error("indefinite length with nonzero length");

endmodule

bind ber_tlv_integer_decoder btid_checker u_btid_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.content_length (content_length),
	.int_value      (int_value),
	.status         (status)
);

>>> tb/sv/tb_ber_tlv_integer_decoder.sv
// tb_ber_tlv_integer_decoder: self-checking bench for the ber tlv integer decoder
// predicts each decoded element and compares it field by field with the dut results
// depends on btid_pkg and ber_tlv_integer_decoder
`timescale 1ns / 1ps

module tb_ber_tlv_integer_decoder;
	import btid_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE_WAIT  = 16;
	localparam int RESULT_WAIT  = 2000;
	localparam int STREAM_ITEMS = 1950;
	localparam int MAX_PRINTS   = 100;

	typedef enum logic [2:0] {
		SEEK_ID,
		HIGH_TAG,
		LEN_FIRST,
		LEN_MORE,
		VALUE_OCTETS
	} parse_phase_t;

	typedef struct packed {
		logic [1:0]  cls;
		logic        cons;
		logic [55:0] tag;
		logic [63:0] len;
		logic [63:0] val;
		logic [2:0]  st;
	} element_t;

	typedef struct packed {
		logic [7:0] octet;
		logic       ended;
		logic       drain;
	} stream_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = 8'h00;
	logic        data_ended = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  tag_class;
	logic        constructed;
	logic [55:0] tag_number;
	logic [63:0] content_length;
	logic [63:0] int_value;
	logic [2:0]  status;

	ber_tlv_integer_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.data_ended(data_ended),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tag_class(tag_class),
		.constructed(constructed),
		.tag_number(tag_number),
		.content_length(content_length),
		.int_value(int_value),
		.status(status)
	);

	always #5 clk = ~clk;

	stream_item_t stream_octets[$];
	element_t     expected_elements[$];

	int cycle_count = 0;
	int mismatches = 0;
	int stream_count = 0;
	int octets_accepted = 0;
	int elements_checked = 0;
	int status_tally[0:5] = '{0, 0, 0, 0, 0, 0};
	int long_holds = 0;
	int drains = 0;
	logic in_taken = 1'b0;

	// decoder state mirror
	parse_phase_t pphase = SEEK_ID;
	logic [1:0]   el_class = '0;
	logic         el_cons = 1'b0;
	logic [55:0]  el_tag = '0;
	logic [3:0]   el_tag_count = '0;
	logic [63:0]  el_len = '0;
	logic [3:0]   el_len_left = '0;
	logic [63:0]  el_val = '0;
	logic [3:0]   el_val_left = '0;

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	task automatic clear_element();
		el_class = '0;
		el_cons = 1'b0;
		el_tag = '0;
		el_tag_count = '0;
		el_len = '0;
		el_len_left = '0;
		el_val = '0;
		el_val_left = '0;
	endtask

	task automatic close_element(input logic [2:0] st);
		element_t e;
		e.cls = el_class;
		e.cons = el_cons;
		e.tag = el_tag;
		e.len = el_len;
		e.val = (st == ST_OK) ? el_val : 64'd0;
		e.st = st;
		expected_elements.push_back(e);
		pphase = SEEK_ID;
	endtask

	task automatic open_value();
		if (el_len < 64'd1 || el_len > 64'd8) begin
			close_element(ST_BADINT);
		end else begin
			el_val = '0;
			el_val_left = el_len[3:0];
			pphase = VALUE_OCTETS;
		end
	endtask

	task automatic decode_octet(input logic [7:0] b, input logic ended);
		if (ended) begin
			if (pphase == SEEK_ID)
				clear_element();
			close_element(ST_TRUNC);
		end else begin
			case (pphase)
				SEEK_ID: begin
					clear_element();
					el_class = b[7:6];
					el_cons = b[5];
					if (b[4:0] == HIGH_TAG_MARK) begin
						el_tag = '0;
						pphase = HIGH_TAG;
					end else begin
						el_tag = {51'd0, b[4:0]};
						pphase = LEN_FIRST;
					end
				end
				HIGH_TAG: begin
					el_tag = {el_tag[48:0], b[6:0]};
					el_tag_count = el_tag_count + 4'd1;
					if (b[7]) begin
						if (el_tag_count >= DEF_MAX_TAG_OCTETS)
							close_element(ST_TAGLONG);
					end else if (el_tag < 56'd31) begin
						close_element(ST_TAGLONG);
					end else begin
						pphase = LEN_FIRST;
					end
				end
				LEN_FIRST: begin
					if (!b[7]) begin
						el_len = {57'd0, b[6:0]};
						open_value();
					end else if (b[6:0] == 7'd0) begin
						close_element(ST_INDEF);
					end else if (b[6:0] > DEF_MAX_LENGTH_OCTETS) begin
						close_element(ST_LENOCT);
					end else begin
						el_len = '0;
						el_len_left = b[3:0];
						pphase = LEN_MORE;
					end
				end
				LEN_MORE: begin
					el_len = {el_len[55:0], b};
					if (el_len_left > 0)
						el_len_left = el_len_left - 4'd1;
					if (el_len_left == 0)
						open_value();
				end
				VALUE_OCTETS: begin
					el_val = {el_val[55:0], b};
					if (el_val_left > 0)
						el_val_left = el_val_left - 4'd1;
					if (el_val_left == 0)
						close_element(ST_OK);
				end
				default: begin
					pphase = SEEK_ID;
				end
			endcase
		end
	endtask

	task automatic check_element();
		element_t want;
		if (expected_elements.size() == 0) begin
			report_mismatch($sformatf("result with nothing expected, status %0d", status));
		end else begin
			want = expected_elements.pop_front();
			elements_checked++;
			status_tally[want.st]++;
			if (tag_class !== want.cls)
				report_mismatch($sformatf("tag_class %0d, want %0d", tag_class, want.cls));
			if (constructed !== want.cons)
				report_mismatch($sformatf("constructed %0b, want %0b", constructed, want.cons));
			if (tag_number !== want.tag)
				report_mismatch($sformatf("tag_number %h, want %h", tag_number, want.tag));
			if (content_length !== want.len)
				report_mismatch($sformatf("content_length %h, want %h", content_length,
					want.len));
			if (int_value !== want.val)
				report_mismatch($sformatf("int_value %h, want %h", int_value, want.val));
			if (status !== want.st)
				report_mismatch($sformatf("status %0d, want %0d", status, want.st));
		end
	endtask

	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic push_octet(input logic [7:0] b);
		stream_item_t s;
		s.octet = b;
		s.ended = 1'b0;
		s.drain = 1'b0;
		stream_octets.push_back(s);
		stream_count++;
	endtask

	task automatic push_ended();
		stream_item_t s;
		s.octet = 8'($urandom_range(0, 255));
		s.ended = 1'b1;
		s.drain = 1'b0;
		stream_octets.push_back(s);
		stream_count++;
	endtask

	task automatic push_drain();
		stream_item_t s;
		s.octet = 8'h00;
		s.ended = 1'b0;
		s.drain = 1'b1;
		stream_octets.push_back(s);
	endtask

	task automatic queue_random_element();
		logic [7:0] octs[$];
		logic [7:0] id;
		logic [7:0] b;
		int kind, n, hi, vlen, k, r, i, len_idx, cut;
		bit long_tag;
		kind = $urandom_range(0, 99);
		if (kind >= 92) begin
			// noise
			n = $urandom_range(1, 4);
			for (i = 0; i < n; i++) begin
				if ($urandom_range(0, 9) == 0)
					push_ended();
				else
					push_octet(8'($urandom_range(0, 255)));
			end
			return;
		end
		id = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 3) == 0) begin
			id[4:0] = HIGH_TAG_MARK;
			octs.push_back(id);
			long_tag = ($urandom_range(0, 9) == 0);
			hi = ($urandom_range(0, 3) == 0) ? DEF_MAX_TAG_OCTETS : 2;
			n = long_tag ? DEF_MAX_TAG_OCTETS : $urandom_range(1, hi);
			for (i = 0; i < n; i++) begin
				b = 8'($urandom_range(0, 127));
				if (long_tag || i < n - 1)
					b[7] = 1'b1;
				octs.push_back(b);
			end
		end else begin
			if (id[4:0] == HIGH_TAG_MARK)
				id[4:0] = 5'($urandom_range(0, 30));
			octs.push_back(id);
		end
		len_idx = octs.size();
		vlen = $urandom_range(1, MAX_INT_OCTETS);
		if ($urandom_range(0, 2) != 0) begin
			octs.push_back(8'(vlen));
		end else begin
			k = $urandom_range(1, DEF_MAX_LENGTH_OCTETS);
			octs.push_back(8'h80 | 8'(k));
			for (i = 1; i < k; i++)
				octs.push_back(8'h00);
			octs.push_back(8'(vlen));
		end
		for (i = 0; i < vlen; i++) begin
			r = $urandom_range(0, 9);
			octs.push_back(r == 0 ? 8'h00 : (r == 1 ? 8'hff : 8'($urandom_range(0, 255))));
		end
		if (kind >= 75 && kind < 82) begin
			// corrupt one octet
			octs[$urandom_range(0, octs.size() - 1)] = 8'($urandom_range(0, 255));
		end else if (kind >= 82 && kind < 87) begin
			// bad length field
			while (octs.size() > len_idx + 1)
				void'(octs.pop_back());
			r = $urandom_range(0, 4);
			case (r)
				0: octs[len_idx] = 8'h80;
				1: octs[len_idx] = 8'h80 | 8'($urandom_range(9, 127));
				2: octs[len_idx] = 8'($urandom_range(9, 127));
				3: octs[len_idx] = 8'h00;
				default: begin
					octs[len_idx] = 8'h88;
					long_tag = ($urandom_range(0, 9) == 0);
					for (i = 0; i < 8; i++) begin
						b = long_tag ? 8'hff : 8'($urandom_range(0, 255));
						if (i == 0 && b == 8'h00)
							b = 8'h01;
						octs.push_back(b);
					end
				end
			endcase
		end
		cut = octs.size();
		if (kind >= 87 && kind < 92)
			cut = $urandom_range(1, octs.size() - 1);
		for (i = 0; i < cut; i++)
			push_octet(octs[i]);
		if (cut < octs.size())
			push_ended();
	endtask

	// item feed, changes at the falling edge
	int  send_gap = 0;
	bit  send_calm = 1'b0;
	always @(negedge clk) begin
		stream_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
			in_valid <= 1'b1;
		end else if (send_gap > 0) begin
			send_gap--;
			in_valid <= 1'b0;
		end else if (stream_octets.size() == 0) begin
			in_valid <= 1'b0;
		end else if (stream_octets[0].drain) begin
			in_valid <= 1'b0;
			if (expected_elements.size() == 0) begin
				void'(stream_octets.pop_front());
				drains++;
			end
		end else begin
			nxt = stream_octets.pop_front();
			in_valid <= 1'b1;
			in_byte <= nxt.octet;
			data_ended <= nxt.ended;
			if ($urandom_range(0, 199) == 0)
				send_calm = !send_calm;
			send_gap = pick_gap(send_calm);
		end
	end

	// result side stall, with long holds counted here
	int  stall_left = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	bit  recv_calm = 1'b0;
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (hold_left == 0 &&
			    ((!hold_done && octets_accepted >= 500) || $urandom_range(0, 3999) == 0)) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
				long_holds++;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				if ($urandom_range(0, 199) == 0)
					recv_calm = !recv_calm;
				stall_left = pick_gap(recv_calm);
				if (stall_left > 0) begin
					stall_left--;
					out_stall <= 1'b1;
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	// sampling at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				octets_accepted++;
				decode_octet(in_byte, data_ended);
			end
			if (out_valid && !out_stall)
				check_element();
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("ber_tlv_integer_decoder verification failed");
			$finish;
		end
	end

	initial begin
		int waited;
		// truncated in idle
		push_ended();
		// short integer, value zero
		push_octet(8'h02); push_octet(8'h01); push_octet(8'h00);
		// two-octet high tag, long-form length, all-ones value
		push_octet(8'hff); push_octet(8'hff); push_octet(8'h7f);
		push_octet(8'h81); push_octet(8'h01); push_octet(8'hff);
		// high tag below 31
		push_octet(8'h1f); push_octet(8'h1e);
		// indefinite length
		push_octet(8'h00); push_octet(8'h80);
		// too many length octets
		push_octet(8'h40); push_octet(8'h89);
		// zero integer length
		push_octet(8'h80); push_octet(8'h00);
		// integer length over 8
		push_octet(8'h30); push_octet(8'h09);
		// truncated inside the value
		push_octet(8'h21); push_octet(8'h03); push_octet(8'hab); push_ended();
		push_drain();
		while (stream_count < STREAM_ITEMS) begin
			queue_random_element();
			if (stream_count % 400 < 6 && stream_count > 400)
				push_drain();
		end
		push_drain();

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		while (stream_octets.size() != 0 || in_valid)
			@(negedge clk);
		waited = 0;
		while (expected_elements.size() != 0 && waited < RESULT_WAIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_WAIT) @(negedge clk);
		if (expected_elements.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_elements.size()));

		$display("run covered %0d octets, %0d elements: ok %0d, tag %0d, indefinite %0d, %s",
			octets_accepted, elements_checked, status_tally[0], status_tally[1],
			status_tally[2], $sformatf("length octets %0d, bad length %0d, truncated %0d",
			status_tally[3], status_tally[4], status_tally[5]));
		$display("receiver long holds %0d, sender drains %0d, mismatches %0d",
			long_holds, drains, mismatches);
		if (mismatches == 0) begin
			$display("ber_tlv_integer_decoder verification clean");
		end else begin
			$display("ber_tlv_integer_decoder verification failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/btid_pkg.sv
rtl/core/ber_tlv_integer_decoder.sv
rtl/core/btid_checker.sv
tb/sv/tb_ber_tlv_integer_decoder.sv
